// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the circle pixel shader.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked on every rising edge of aclk, off while in reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Condition that must never be seen on a rising edge of aclk
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ===== src/lcps_pkg.sv =====
// Types and constants of the layered circle pixel shader.
package lcps_pkg;

    // Field widths
    localparam int FUNC_W   = 2;
    localparam int LETTER_W = 8;
    localparam int COORD_W  = 20;
    localparam int RAD_W    = 19;
    localparam int PAINT_W  = 8;
    localparam int PIX_W    = 9;
    localparam int FRAC_W   = 8;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 16;

    // Squaring datapath: operand covers pixel minus center and the radius terms
    localparam int OPD_W = 21;
    localparam int SQ_W  = 2 * OPD_W;
    localparam int SUM_W = SQ_W + 1;
    localparam int R2_W  = 2 * RAD_W;

    localparam logic [LETTER_W-1:0] LETTER_FILLED  = 8'h43;
    localparam logic [LETTER_W-1:0] LETTER_OUTLINE = 8'h63;
    localparam logic signed [OPD_W-1:0] ONE_UNIT   = 21'sd256;
    localparam logic [RAD_W-1:0] THIN_LIMIT        = 19'd256;
    localparam logic [PAINT_W-1:0] BG_RESET        = 8'd32;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_ADD   = 2'd1,
        FUNC_QUERY = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_BAD_LETTER = 2'd1,
        ST_BAD_VALUE  = 2'd2,
        ST_FULL       = 2'd3
    } status_t;

    // One stored circle, squares precomputed at load
    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [R2_W-1:0]    r2;
        logic [R2_W-1:0]    inner2;
        logic               thin;
        logic               filled;
        logic [PAINT_W-1:0] paint;
    } circle_t;

    // Control of the shared squaring unit
    typedef struct packed {
        logic valid;
        logic acc;
    } sq_ctrl_t;

endpackage

// ===== src/lcps_sq_unit.sv =====
// Shared square and accumulate unit: one multiplier, one adder.
module lcps_sq_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  lcps_pkg::sq_ctrl_t                   ctrl,
    input  logic signed [lcps_pkg::OPD_W-1:0]    opd,
    output logic [lcps_pkg::SUM_W-1:0]           sum
);
    import lcps_pkg::*;

    logic signed [SQ_W-1:0] prod_s;
    logic [SQ_W-1:0]        prod_reg;
    logic                   en_reg;
    logic                   hold_reg;
    logic [SUM_W-1:0]       sum_reg;

    assign prod_s = SQ_W'(opd) * SQ_W'(opd);

    // Stage 1: square; stage 2: add into or replace the sum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg   <= 1'b0;
            hold_reg <= 1'b0;
        end else begin
            en_reg   <= ctrl.valid;
            hold_reg <= ctrl.acc;
        end
        prod_reg <= unsigned'(prod_s);
        if (en_reg) begin
            sum_reg <= (hold_reg ? sum_reg : '0) + {1'b0, prod_reg};
        end
    end

    assign sum = sum_reg;

endmodule

// ===== src/lcps_circle_table.sv =====
// Circle table: one write port, one registered read port.
module lcps_circle_table #(
    parameter int MAX_CIRCLES = 16,
    parameter int IDX_W       = 4
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  lcps_pkg::circle_t     wr_data,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_addr,
    output lcps_pkg::circle_t     rd_data
);
    import lcps_pkg::*;

    circle_t mem_reg [MAX_CIRCLES];
    circle_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/layered_circle_pixel_shader.sv =====
// Top level of the layered circle pixel shader: sequencer and I/O registers.
//
//  channel   dir  handshake            word
//  s_        in   s_tvalid/s_tready    func, letter, center, radius, paint, pixel
//  m_        out  m_tvalid/m_tready    pixel_char, status
//  cfg_      in   cfg_we               background byte
//
// One word at a time; s_tready is high only while the sequencer is idle.
// A clear, an unused func, a rejected add, or an off-canvas or empty-table query goes
// straight to the result; an accepted add first squares radius and inner radius on the
// shared unit; a query steps through every stored circle, and each circle needs dx and
// dy squared on the one multiplier and a table read.
// Reset (aresetn, synchronous) empties the table and sets background to 32.
// A result waits in the output register; a stalled m_ side holds the sequencer.
module layered_circle_pixel_shader #(
    parameter int MAX_CIRCLES = 16,
    parameter int MAX_SIDE    = 512
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // func, shape_letter, center_x, center_y, radius, paint, pixel_x, pixel_y
    input  logic [lcps_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // pixel_char, status
    output logic [lcps_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_we,
    input  logic [lcps_pkg::PAINT_W-1:0]   cfg_wdata
);
    import lcps_pkg::*;

    localparam int CNT_W = $clog2(MAX_CIRCLES + 1);
    localparam int IDX_W = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_LD_R  = 11'b000_0000_0010,
        S_LD_I  = 11'b000_0000_0100,
        S_LD_W1 = 11'b000_0000_1000,
        S_LD_W2 = 11'b000_0001_0000,
        S_Q_RD  = 11'b000_0010_0000,
        S_Q_DX  = 11'b000_0100_0000,
        S_Q_DY  = 11'b000_1000_0000,
        S_Q_ACC = 11'b001_0000_0000,
        S_Q_CMP = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Input word fields
    logic [FUNC_W-1:0]   in_func;
    logic [LETTER_W-1:0] in_letter;
    logic [COORD_W-1:0]  in_cx;
    logic [COORD_W-1:0]  in_cy;
    logic [RAD_W-1:0]    in_rad;
    logic [PAINT_W-1:0]  in_paint;
    logic [PIX_W-1:0]    in_px;
    logic [PIX_W-1:0]    in_py;

    assign in_func   = s_tdata[1:0];
    assign in_letter = s_tdata[9:2];
    assign in_cx     = s_tdata[29:10];
    assign in_cy     = s_tdata[49:30];
    assign in_rad    = s_tdata[68:50];
    assign in_paint  = s_tdata[76:69];
    assign in_px     = s_tdata[85:77];
    assign in_py     = s_tdata[94:86];

    // Payload registers
    logic [COORD_W-1:0]  cx_reg;
    logic [COORD_W-1:0]  cy_reg;
    logic [RAD_W-1:0]    rad_reg;
    logic [PAINT_W-1:0]  paint_reg;
    logic                filled_reg;
    logic [PIX_W-1:0]    px_reg;
    logic [PIX_W-1:0]    py_reg;
    logic [R2_W-1:0]     r2_reg;
    logic [PAINT_W-1:0]  pix_reg, pix_next;
    status_t             status_reg, status_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Control registers
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [PAINT_W-1:0]  bg_reg;
    logic                m_tvalid_reg, m_tvalid_next;

    logic s_acc;
    logic out_free;
    logic full;
    logic in_canvas;
    logic last_circle;
    logic covers;

    // Status field of the word on the m_ side
    status_t m_status;

    circle_t tbl_rd;
    circle_t tbl_wr;
    logic    tbl_we;
    logic    tbl_re;

    sq_ctrl_t                 sq_ctrl;
    logic signed [OPD_W-1:0]  sq_opd;
    logic [SUM_W-1:0]         sq_sum;

    logic signed [OPD_W-1:0]  px_s, py_s, cx_s, cy_s, rad_s;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign full      = (count_reg == CNT_W'(MAX_CIRCLES));
    assign in_canvas = (32'(in_px) < MAX_SIDE) && (32'(in_py) < MAX_SIDE);
    assign last_circle = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    // Operands in units of 1/256
    assign px_s  = $signed({{(OPD_W-PIX_W-FRAC_W){1'b0}}, px_reg, {FRAC_W{1'b0}}});
    assign py_s  = $signed({{(OPD_W-PIX_W-FRAC_W){1'b0}}, py_reg, {FRAC_W{1'b0}}});
    assign cx_s  = $signed({{(OPD_W-COORD_W){tbl_rd.cx[COORD_W-1]}}, tbl_rd.cx});
    assign cy_s  = $signed({{(OPD_W-COORD_W){tbl_rd.cy[COORD_W-1]}}, tbl_rd.cy});
    assign rad_s = $signed({{(OPD_W-RAD_W){1'b0}}, rad_reg});

    // Coverage test on the finished squared distance
    always_comb begin
        if (sq_sum > {{(SUM_W-R2_W){1'b0}}, tbl_rd.r2}) begin
            covers = 1'b0;
        end else if (tbl_rd.filled || tbl_rd.thin) begin
            covers = 1'b1;
        end else begin
            covers = (sq_sum > {{(SUM_W-R2_W){1'b0}}, tbl_rd.inner2});
        end
    end

    // Squaring unit operand select
    always_comb begin
        sq_ctrl = '0;
        sq_opd  = '0;
        unique case (state_reg)
            S_LD_R: begin
                sq_ctrl = '{valid: 1'b1, acc: 1'b0};
                sq_opd  = rad_s;
            end
            S_LD_I: begin
                sq_ctrl = '{valid: 1'b1, acc: 1'b0};
                sq_opd  = rad_s - ONE_UNIT;
            end
            S_Q_DX: begin
                sq_ctrl = '{valid: 1'b1, acc: 1'b0};
                sq_opd  = px_s - cx_s;
            end
            S_Q_DY: begin
                sq_ctrl = '{valid: 1'b1, acc: 1'b1};
                sq_opd  = py_s - cy_s;
            end
            default: begin
                sq_ctrl = '0;
                sq_opd  = '0;
            end
        endcase
    end

    // Table write on the last load step
    assign tbl_we = (state_reg == S_LD_W2);
    assign tbl_re = (state_reg == S_Q_RD);
    assign tbl_wr = '{cx: cx_reg, cy: cy_reg, r2: r2_reg, inner2: sq_sum[R2_W-1:0],
                      thin: (rad_reg < THIN_LIMIT), filled: filled_reg, paint: paint_reg};

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        pix_next      = pix_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    pix_next    = '0;
                    status_next = ST_OK;
                    state_next  = S_DONE;
                    unique case (func_t'(in_func))
                        FUNC_CLEAR: count_next = '0;
                        FUNC_ADD: begin
                            if (in_letter != LETTER_FILLED && in_letter != LETTER_OUTLINE) begin
                                status_next = ST_BAD_LETTER;
                            end else if (in_rad == '0 || in_paint == '0) begin
                                status_next = ST_BAD_VALUE;
                            end else if (full) begin
                                status_next = ST_FULL;
                            end else begin
                                state_next = S_LD_R;
                            end
                        end
                        FUNC_QUERY: begin
                            pix_next = bg_reg;
                            idx_next = '0;
                            if (in_canvas && count_reg != '0) begin
                                state_next = S_Q_RD;
                            end
                        end
                        FUNC_NONE: ;
                        default: ;
                    endcase
                end
            end
            S_LD_R:  state_next = S_LD_I;
            S_LD_I:  state_next = S_LD_W1;
            S_LD_W1: state_next = S_LD_W2;
            S_LD_W2: begin
                count_next = count_reg + CNT_W'(1);
                state_next = S_DONE;
            end
            S_Q_RD:  state_next = S_Q_DX;
            S_Q_DX:  state_next = S_Q_DY;
            S_Q_DY:  state_next = S_Q_ACC;
            S_Q_ACC: state_next = S_Q_CMP;
            S_Q_CMP: begin
                if (covers) begin
                    pix_next = tbl_rd.paint;
                end
                if (last_circle) begin
                    state_next = S_DONE;
                end else begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_Q_RD;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(M_DATA_W-PAINT_W-STATUS_W){1'b0}}, status_reg, pix_reg};
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            bg_reg       <= BG_RESET;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                bg_reg <= cfg_wdata;
            end
        end
    end

    // Payload capture
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            cx_reg     <= in_cx;
            cy_reg     <= in_cy;
            rad_reg    <= in_rad;
            paint_reg  <= in_paint;
            filled_reg <= (in_letter == LETTER_FILLED);
            px_reg     <= in_px;
            py_reg     <= in_py;
        end
        if (state_reg == S_LD_W1) begin
            r2_reg <= sq_sum[R2_W-1:0];
        end
        pix_reg     <= pix_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_status = status_t'(m_tdata_reg[PAINT_W+STATUS_W-1:PAINT_W]);

    lcps_sq_unit u_sq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (sq_ctrl),
        .opd     (sq_opd),
        .sum     (sq_sum)
    );

    lcps_circle_table #(
        .MAX_CIRCLES (MAX_CIRCLES),
        .IDX_W       (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_we),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (tbl_wr),
        .rd_en   (tbl_re),
        .rd_addr (idx_reg),
        .rd_data (tbl_rd)
    );

    // Checks
`include "assert_macros.svh"

    `ASSERT_NEVER(a_count_range, count_reg > CNT_W'(MAX_CIRCLES), "count over table size")
    `ASSERT_CLK(a_idx_range, state_reg == S_Q_CMP |-> CNT_W'(idx_reg) < count_reg, "idx past count")
    `ASSERT_CLK(a_load, state_reg == S_LD_W2 |=> count_reg == $past(count_reg) + CNT_W'(1), "no add")
    `ASSERT_CLK(a_err_no_pix, m_tvalid && m_status != ST_OK |-> m_tdata[7:0] == '0, "pix on reject")

endmodule
